[hdl/hbs_pkg.sv]
// Shared constants, register codes and control structs of the 3x3 heightmap box smoother.
// Used by the channel interfaces, the controller, the datapath, the divider and the top level.
// No dependencies.
package hbs_pkg;

    // Line store depth and derived widths
    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = COL_W + 1;

    // Field widths
    localparam int ROW_W      = 16;
    localparam int SAMPLE_W   = 8;
    localparam int HEIGHT_W   = 24;
    localparam int SCALE_W    = 16;
    localparam int NCOLCFG_W  = 11;
    localparam int TRI_W      = SAMPLE_W + 2;
    localparam int SUM_W      = 12;
    localparam int DIVC_W     = 4;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int DSTEP_W    = $clog2(PROD_W);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;

    localparam logic [ROW_W-1:0]     RST_NUM_ROWS     = 16'd256;
    localparam logic [NCOLCFG_W-1:0] RST_NUM_COLUMNS  = 11'd256;
    localparam logic [SCALE_W-1:0]   RST_HEIGHT_SCALE = 16'd256;

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch_in;
        logic       rd_en;
        logic       rd_drain;
        logic [1:0] drain_step;
        logic       drain_clr;
        logic       drain_acc;
        logic       sample_upd;
        logic       drain_fin;
        logic       restart;
        logic       mul_load;
        logic       div_start;
        logic       out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic frame_complete;
        logic drain_past;
        logic job_pending;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[hdl/hbs_in_if.sv]
// Input channel of the box smoother: valid/ready handshake with kind and sample.
// Depends on hbs_pkg.
interface hbs_in_if import hbs_pkg::*;;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

[hdl/hbs_out_if.sv]
// Output channel of the box smoother: valid/ready handshake with one result item.
// Depends on hbs_pkg.
interface hbs_out_if import hbs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    logic [ROW_W-1:0]    row_index;
    logic [COL_W-1:0]    column_index;
    logic                last_in_run;
    logic                frame_end;

    modport source (output valid, output height, output row_index, output column_index,
                    output last_in_run, output frame_end, input ready);
    modport sink   (input valid, input height, input row_index, input column_index,
                    input last_in_run, input frame_end, output ready);
endinterface

[hdl/hbs_cfg_if.sv]
// Configuration write channel of the box smoother: valid/ready with register index and data.
// Depends on hbs_pkg.
interface hbs_cfg_if import hbs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/hbs_div.sv]
// Restoring divider: one quotient bit per cycle, small divisor (neighbourhood count).
// Depends on hbs_pkg.
module hbs_div import hbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DIVC_W-1:0] i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic               r_busy;
    logic               r_done;
    logic [DSTEP_W-1:0] r_step;
    logic [PROD_W-1:0]  r_quo;
    logic [DIVC_W-1:0]  r_rem;
    logic [DIVC_W-1:0]  r_div;

    logic [DIVC_W:0]    w_shift;
    logic               w_ge;
    logic [DIVC_W:0]    w_rem_n;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_shift = {r_rem, r_quo[PROD_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_rem_n = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
    end

    // Step through all dividend bits, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
            r_rem <= w_rem_n[DIVC_W-1:0];
            if (r_step == DSTEP_W'(PROD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_step <= r_step + DSTEP_W'(1);
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/hbs_datapath.sv]
// Datapath of the box smoother: configuration registers, line stores, 3x3 window,
// position counters, result job queue, scale multiplier, divider and output register.
// Depends on hbs_pkg and hbs_div.
module hbs_datapath import hbs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [HEIGHT_W-1:0]   o_height,
    output logic [ROW_W-1:0]      o_row_index,
    output logic [COL_W-1:0]      o_column_index,
    output logic                  o_last_in_run,
    output logic                  o_frame_end
);

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [DIVC_W-1:0] cnt;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
        logic              fend;
    } t_job;

    function automatic logic [DIVC_W-1:0] f_cnt(input logic [1:0] a, input logic [1:0] b);
        f_cnt = DIVC_W'(a) * DIVC_W'(b);
    endfunction

    // Configuration
    logic [ROW_W-1:0]     r_num_rows;
    logic [NCOLCFG_W-1:0] r_num_cols;
    logic [SCALE_W-1:0]   r_scale;

    // Position state
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_drain, n_drain;
    logic             r_fc, n_fc;

    // Line stores and read data
    logic [SAMPLE_W-1:0] r_older_mem [MAX_COLUMNS];
    logic [SAMPLE_W-1:0] r_newer_mem [MAX_COLUMNS];
    logic [SAMPLE_W-1:0] r_rd_old;
    logic [SAMPLE_W-1:0] r_rd_new;
    logic                r_rd_ok;

    // Window: index 0 = two columns back, index 1 = one column back
    logic [SAMPLE_W-1:0] r_win_top [2];
    logic [SAMPLE_W-1:0] r_win_mid [2];
    logic [SAMPLE_W-1:0] r_win_bot [2];

    logic [SAMPLE_W-1:0] r_sample;
    logic [SUM_W-1:0]    r_dsum;
    logic [1:0]          r_dncol;

    t_job                r_job [2];
    logic [1:0]          r_njobs;
    t_job                r_meta;
    logic [PROD_W-1:0]   r_prod;

    logic                r_out_valid;
    logic [HEIGHT_W-1:0] r_out_height;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic                r_out_last;
    logic                r_out_fend;

    // Combinational signals
    logic [CNT_W-1:0]    w_cols;
    logic [ROW_W:0]      w_rows;
    logic [CNT_W:0]      w_dt;
    logic [CNT_W:0]      w_dt1;
    logic                w_dvalid;
    logic [COL_W-1:0]    w_addr;
    logic                w_use_top;
    logic [SAMPLE_W-1:0] w_top_m;
    logic [TRI_W-1:0]    w_cur;
    logic [TRI_W-1:0]    w_b;
    logic [TRI_W-1:0]    w_a;
    logic                w_last_col;
    logic                w_job_a_v;
    logic                w_job_b_v;
    logic [1:0]          w_nrow;
    t_job                w_job_a;
    t_job                w_job_b;
    t_job                w_job_d;
    logic [SUM_W-1:0]    w_dadd;
    logic [SUM_W-1:0]    w_dsum_n;
    logic [1:0]          w_dncol_n;
    logic                w_dend;
    logic                w_div_done;
    logic [PROD_W-1:0]   w_quo;

    // Effective frame size
    always_comb begin
        if (r_num_cols == '0) begin
            w_cols = CNT_W'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLUMNS)) begin
            w_cols = CNT_W'(MAX_COLUMNS);
        end else begin
            w_cols = CNT_W'(r_num_cols);
        end
        w_rows = (r_num_rows == '0) ? (ROW_W+1)'(1) : (ROW_W+1)'(r_num_rows);
    end

    // Line store address: current column for samples, drain column plus offset for drains
    always_comb begin
        w_dt     = (CNT_W+1)'(r_drain) + (CNT_W+1)'(i_cmd.drain_step);
        w_dt1    = w_dt - (CNT_W+1)'(1);
        w_dvalid = (w_dt != '0) && (w_dt1 < (CNT_W+1)'(w_cols));
        w_addr   = i_cmd.rd_drain ? w_dt1[COL_W-1:0] : r_col;
    end

    // Column sums and results of a sample item
    always_comb begin
        w_use_top  = (r_row > ROW_W'(1));
        w_top_m    = w_use_top ? r_rd_old : '0;
        w_cur      = TRI_W'(r_rd_new) + TRI_W'(r_sample) + TRI_W'(w_top_m);
        w_b        = TRI_W'(r_win_mid[1]) + TRI_W'(r_win_bot[1])
                   + (w_use_top ? TRI_W'(r_win_top[1]) : '0);
        w_a        = TRI_W'(r_win_mid[0]) + TRI_W'(r_win_bot[0])
                   + (w_use_top ? TRI_W'(r_win_top[0]) : '0);
        w_last_col = ((CNT_W'(r_col) + CNT_W'(1)) >= w_cols);
        w_nrow     = w_use_top ? 2'd3 : 2'd2;
        w_job_a_v  = (r_row != '0) && (r_col != '0);
        w_job_b_v  = (r_row != '0) && w_last_col;

        w_job_a.sum  = SUM_W'(w_b) + SUM_W'(w_cur)
                     + ((r_col > COL_W'(1)) ? SUM_W'(w_a) : '0);
        w_job_a.cnt  = f_cnt(w_nrow, (r_col > COL_W'(1)) ? 2'd3 : 2'd2);
        w_job_a.row  = r_row - ROW_W'(1);
        w_job_a.col  = r_col - COL_W'(1);
        w_job_a.last = !w_job_b_v;
        w_job_a.fend = 1'b0;

        w_job_b.sum  = SUM_W'(w_cur) + ((r_col != '0) ? SUM_W'(w_b) : '0);
        w_job_b.cnt  = f_cnt(w_nrow, (r_col != '0) ? 2'd2 : 2'd1);
        w_job_b.row  = r_row - ROW_W'(1);
        w_job_b.col  = r_col;
        w_job_b.last = 1'b1;
        w_job_b.fend = 1'b0;
    end

    // Drain accumulation and the drain result
    always_comb begin
        w_dadd    = SUM_W'(r_rd_new) + ((r_row != '0) ? SUM_W'(r_rd_old) : '0);
        w_dsum_n  = r_dsum;
        w_dncol_n = r_dncol;
        if (i_cmd.drain_acc && r_rd_ok) begin
            w_dsum_n  = r_dsum + w_dadd;
            w_dncol_n = r_dncol + 2'd1;
        end
        w_dend       = (((CNT_W+1)'(r_drain) + (CNT_W+1)'(1)) >= (CNT_W+1)'(w_cols));
        w_job_d.sum  = w_dsum_n;
        w_job_d.cnt  = f_cnt((r_row != '0) ? 2'd2 : 2'd1, w_dncol_n);
        w_job_d.row  = r_row;
        w_job_d.col  = r_drain[COL_W-1:0];
        w_job_d.last = 1'b1;
        w_job_d.fend = w_dend;
    end

    // Next position state
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_drain = r_drain;
        n_fc    = r_fc;
        if (i_cmd.restart || (i_cmd.drain_fin && w_dend)) begin
            n_row   = '0;
            n_col   = '0;
            n_drain = '0;
            n_fc    = 1'b0;
        end else if (i_cmd.drain_fin) begin
            n_drain = r_drain + CNT_W'(1);
        end else if (i_cmd.sample_upd) begin
            if (w_last_col) begin
                n_col = '0;
                if (((ROW_W+1)'(r_row) + (ROW_W+1)'(1)) >= w_rows) begin
                    n_fc    = 1'b1;
                    n_drain = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Control state: configuration, counters, job count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= RST_NUM_ROWS;
            r_num_cols  <= RST_NUM_COLUMNS;
            r_scale     <= RST_HEIGHT_SCALE;
            r_row       <= '0;
            r_col       <= '0;
            r_drain     <= '0;
            r_fc        <= 1'b0;
            r_njobs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS:     r_num_rows <= i_cfg_data[ROW_W-1:0];
                    CFG_NUM_COLUMNS:  r_num_cols <= i_cfg_data[NCOLCFG_W-1:0];
                    CFG_HEIGHT_SCALE: r_scale    <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            r_row   <= n_row;
            r_col   <= n_col;
            r_drain <= n_drain;
            r_fc    <= n_fc;
            if (i_cmd.sample_upd) begin
                r_njobs <= 2'(w_job_a_v) + 2'(w_job_b_v);
            end else if (i_cmd.drain_fin) begin
                r_njobs <= 2'd1;
            end else if (i_cmd.mul_load) begin
                r_njobs <= r_njobs - 2'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line stores: read one address, write back on sample update
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_upd) begin
            r_older_mem[r_col] <= r_rd_new;
        end
        if (i_cmd.rd_en) begin
            r_rd_old <= r_older_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_upd) begin
            r_newer_mem[r_col] <= r_sample;
        end
        if (i_cmd.rd_en) begin
            r_rd_new <= r_newer_mem[w_addr];
        end
    end

    // Payload: input latch, window, drain sum, jobs, product, output item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_sample <= i_sample;
        end
        if (i_cmd.rd_en) begin
            r_rd_ok <= w_dvalid;
        end
        if (i_cmd.drain_clr) begin
            r_dsum  <= '0;
            r_dncol <= '0;
        end else begin
            r_dsum  <= w_dsum_n;
            r_dncol <= w_dncol_n;
        end
        if (i_cmd.sample_upd) begin
            r_win_top[0] <= r_win_top[1];
            r_win_top[1] <= r_rd_old;
            r_win_mid[0] <= r_win_mid[1];
            r_win_mid[1] <= r_rd_new;
            r_win_bot[0] <= r_win_bot[1];
            r_win_bot[1] <= r_sample;
            r_job[0]     <= w_job_a_v ? w_job_a : w_job_b;
            r_job[1]     <= w_job_b;
        end else if (i_cmd.drain_fin) begin
            r_job[0] <= w_job_d;
        end else if (i_cmd.mul_load) begin
            r_meta   <= r_job[0];
            r_prod   <= PROD_W'(r_job[0].sum) * PROD_W'(r_scale);
            r_job[0] <= r_job[1];
        end
        if (i_cmd.out_load) begin
            r_out_height <= w_quo[HEIGHT_W-1:0];
            r_out_row    <= r_meta.row;
            r_out_col    <= r_meta.col;
            r_out_last   <= r_meta.last;
            r_out_fend   <= r_meta.fend;
        end
    end

    // Divide scaled sum by the neighbourhood count
    hbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_meta.cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        o_status.frame_complete = r_fc;
        o_status.drain_past     = (r_drain >= w_cols);
        o_status.job_pending    = (r_njobs != '0);
        o_status.div_done       = w_div_done;
        o_status.out_free       = !r_out_valid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_height       = r_out_height;
    assign o_row_index    = r_out_row;
    assign o_column_index = r_out_col;
    assign o_last_in_run  = r_out_last;
    assign o_frame_end    = r_out_fend;

    // Checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("output item overwritten while pending");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_load |-> (r_njobs != '0))
        else $error("job popped from empty queue");

    a_jobs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_njobs != 2'd3)
        else $error("job queue over two entries");

    a_fc_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc |-> (r_col == '0))
        else $error("frame complete with column in progress");

endmodule

[hdl/hbs_ctrl.sv]
// Controller of the box smoother: sequences line store reads, window update, drain
// accumulation, multiply, divide and output hand-off. Depends on hbs_pkg.
module hbs_ctrl import hbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_kind,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SUPD,
        S_DR,
        S_DFIN,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_PUSH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = w_accept;
                if (w_accept) begin
                    if (i_in_kind == KIND_DRAIN) begin
                        o_cmd.drain_clr = 1'b1;
                        if (i_status.frame_complete && i_status.drain_past) begin
                            o_cmd.restart = 1'b1;
                        end else if (i_status.frame_complete) begin
                            n_state = S_DR;
                            n_step  = 2'd0;
                        end
                    end else if (!i_status.frame_complete) begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SUPD;
            end
            S_SUPD: begin
                o_cmd.sample_upd = 1'b1;
                n_state          = S_MUL;
            end
            S_DR: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_drain   = 1'b1;
                o_cmd.drain_step = r_step;
                o_cmd.drain_acc  = (r_step != 2'd0);
                if (r_step == 2'd2) begin
                    n_state = S_DFIN;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_DFIN: begin
                o_cmd.drain_acc = 1'b1;
                o_cmd.drain_fin = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_load = i_status.job_pending;
                n_state        = i_status.job_pending ? S_DSTART : S_IDLE;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.out_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Checks
    a_idle_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_kind == KIND_DRAIN) && !i_status.frame_complete)
        |=> (r_state == S_IDLE))
        else $error("drain without pending row started work");

    a_late_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_kind == KIND_SAMPLE) && i_status.frame_complete)
        |=> (r_state == S_IDLE))
        else $error("sample past frame started work");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DR) |-> (r_step != 2'd3))
        else $error("drain step out of range");

endmodule

[hdl/heightmap_box_smoother_top.sv]
// Flow: an input item is accepted only while idle, so the block takes no new item until
// every result of the last one is in the output register; an item that starts no work
// returns straight to idle. Each result passes the 28-step restoring divider, one quotient
// bit per cycle, and waits while the output item is held.
// Reset: synchronous, active low; clears counters, frame state and pending results, restores
// registers to 256 rows, 256 columns and scale 1.0. Line stores are not cleared.
// Depends on hbs_pkg, the channel interfaces, hbs_ctrl and hbs_datapath.
module heightmap_box_smoother_top import hbs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hbs_in_if.sink     i_in,
    hbs_cfg_if.sink    i_cfg,
    hbs_out_if.source  o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    // Registers are always writable
    assign i_cfg.ready = 1'b1;

    hbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    hbs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample       (i_in.sample),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_height       (o_out.height),
        .o_row_index    (o_out.row_index),
        .o_column_index (o_out.column_index),
        .o_last_in_run  (o_out.last_in_run),
        .o_frame_end    (o_out.frame_end)
    );

endmodule

[tb/heightmap_box_smoother_top_test.sv]
// Self-checking bench for heightmap_box_smoother_top: raster frames of samples and drains
// feed a local 3x3 box-filter predictor, and every smoothed height is checked in order.
// Depends on hbs_pkg, hbs_in_if, hbs_cfg_if, hbs_out_if and the RTL top level.
module heightmap_box_smoother_top_test;
    import hbs_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 100;
    localparam int RANDOM_ITEMS = 370;
    localparam int HOLD_TICKS   = 400;

    typedef enum int {
        FLAW_NONE,
        FLAW_STRAY_DRAINS,
        FLAW_OVERRUN,
        FLAW_SHORT_DRAIN,
        FLAW_JUNK
    } t_frame_flaw;

    typedef struct {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
    } t_raster_item;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic [ROW_W-1:0]    row_index;
        logic [COL_W-1:0]    column_index;
        logic                last_in_run;
        logic                frame_end;
    } t_smoothed;

    logic i_clk;
    logic i_rst_n;

    // Channel drive registers
    logic                  feed_valid  = 1'b0;
    logic                  feed_kind   = KIND_SAMPLE;
    logic [SAMPLE_W-1:0]   feed_sample = '0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_NUM_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  take_ready  = 1'b0;

    hbs_in_if  in_ch ();
    hbs_cfg_if cfg_ch ();
    hbs_out_if out_ch ();

    assign in_ch.valid   = feed_valid;
    assign in_ch.kind    = feed_kind;
    assign in_ch.sample  = feed_sample;
    assign cfg_ch.valid  = cfg_valid;
    assign cfg_ch.index  = cfg_index;
    assign cfg_ch.data   = cfg_data;
    assign out_ch.ready  = take_ready;

    heightmap_box_smoother_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Predictor state
    logic [SAMPLE_W-1:0]  older_line [MAX_COLUMNS] = '{default: '0};
    logic [SAMPLE_W-1:0]  newer_line [MAX_COLUMNS] = '{default: '0};
    logic [SAMPLE_W-1:0]  win_top [2] = '{default: '0};
    logic [SAMPLE_W-1:0]  win_mid [2] = '{default: '0};
    logic [SAMPLE_W-1:0]  win_bot [2] = '{default: '0};
    logic [ROW_W-1:0]     cur_row    = '0;
    logic [COL_W-1:0]     cur_col    = '0;
    logic [CNT_W-1:0]     drain_col  = '0;
    logic                 frame_done = 1'b0;
    logic [ROW_W-1:0]     rows_reg   = RST_NUM_ROWS;
    logic [NCOLCFG_W-1:0] cols_reg   = RST_NUM_COLUMNS;
    logic [SCALE_W-1:0]   scale_reg  = RST_HEIGHT_SCALE;

    t_raster_item raster_feed [$];
    t_smoothed    expected_heights [$];

    int  src_idle_pct  = 12;
    int  sink_idle_pct = 64;
    int  hold_stretch  = 0;
    int  hold_left     = 0;
    bit  hold_started  = 1'b0;
    bit  raster_taken  = 1'b0;
    int  mismatch_count = 0;
    int  stall_ticks   = 0;

    function automatic int rows_in_use();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function automatic int cols_in_use();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(cols_reg);
    endfunction

    function automatic t_smoothed scaled_mean(int sum, int count, int row, int col, logic fe);
        t_smoothed res;
        longint unsigned h;
        h = (longint'(sum) * longint'(scale_reg)) / longint'(count);
        res.height       = h[HEIGHT_W-1:0];
        res.row_index    = row[ROW_W-1:0];
        res.column_index = col[COL_W-1:0];
        res.last_in_run  = 1'b0;
        res.frame_end    = fe;
        return res;
    endfunction

    function automatic void restart_frame();
        cur_row    = '0;
        cur_col    = '0;
        drain_col  = '0;
        frame_done = 1'b0;
    endfunction

    // Advance the filter by one item and queue the heights it releases
    function automatic void smooth_item(t_raster_item item);
        int cols, d, k, col, r, c, sum, ncol, nrow;
        int cur_sum, b_sum, a_sum;
        logic [SAMPLE_W-1:0] top, mid;
        logic use_top, last_col, fin;
        t_smoothed res [$];
        cols = cols_in_use();
        if (item.kind == KIND_DRAIN) begin
            if (!frame_done) return;
            d = int'(drain_col);
            // columns shrank under the drain: drop the rest of the frame
            if (d >= cols) begin
                restart_frame();
                return;
            end
            nrow = (cur_row >= 1) ? 2 : 1;
            sum  = 0;
            ncol = 0;
            for (k = 0; k < 3; k++) begin
                col = d + k - 1;
                if (col >= 0 && col < cols) begin
                    sum += int'(newer_line[col]);
                    if (nrow == 2) sum += int'(older_line[col]);
                    ncol++;
                end
            end
            fin = (d + 1 >= cols);
            res.push_back(scaled_mean(sum, nrow * ncol, int'(cur_row), d, fin));
            if (fin) restart_frame();
            else drain_col = CNT_W'(d + 1);
        end else begin
            if (frame_done) return;
            r        = int'(cur_row);
            c        = int'(cur_col);
            top      = older_line[c];
            mid      = newer_line[c];
            use_top  = (r >= 2);
            nrow     = use_top ? 3 : 2;
            last_col = (c + 1 >= cols);
            cur_sum  = int'(mid) + int'(item.sample) + (use_top ? int'(top) : 0);
            b_sum    = int'(win_mid[1]) + int'(win_bot[1]) + (use_top ? int'(win_top[1]) : 0);
            a_sum    = int'(win_mid[0]) + int'(win_bot[0]) + (use_top ? int'(win_top[0]) : 0);
            older_line[c] = mid;
            newer_line[c] = item.sample;
            // the left neighbor's window is now complete
            if (r >= 1 && c >= 1) begin
                sum  = b_sum + cur_sum;
                ncol = 2;
                if (c >= 2) begin
                    sum += a_sum;
                    ncol = 3;
                end
                res.push_back(scaled_mean(sum, nrow * ncol, r - 1, c - 1, 1'b0));
            end
            // at the right border the position above closes as well
            if (r >= 1 && last_col) begin
                sum  = cur_sum;
                ncol = 1;
                if (c >= 1) begin
                    sum += b_sum;
                    ncol = 2;
                end
                res.push_back(scaled_mean(sum, nrow * ncol, r - 1, c, 1'b0));
            end
            win_top[0] = win_top[1];
            win_top[1] = top;
            win_mid[0] = win_mid[1];
            win_mid[1] = mid;
            win_bot[0] = win_bot[1];
            win_bot[1] = item.sample;
            if (last_col) begin
                cur_col = '0;
                if (r + 1 >= rows_in_use()) begin
                    frame_done = 1'b1;
                    drain_col  = '0;
                end else begin
                    cur_row = cur_row + ROW_W'(1);
                end
            end else begin
                cur_col = cur_col + COL_W'(1);
            end
        end
        if (res.size() != 0) res[res.size() - 1].last_in_run = 1'b1;
        foreach (res[i]) expected_heights.push_back(res[i]);
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Accept input items into the predictor
    always @(posedge i_clk) begin : accept_raster
        t_raster_item took;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            took.kind   = in_ch.kind;
            took.sample = in_ch.sample;
            smooth_item(took);
            raster_taken <= 1'b1;
        end else begin
            raster_taken <= 1'b0;
        end
    end

    // Offer the next item once the current one is gone, idling at random
    always @(negedge i_clk) begin : drive_raster
        t_raster_item next_item;
        if (i_rst_n && (!feed_valid || raster_taken)) begin
            if (raster_feed.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_item   = raster_feed.pop_front();
                feed_valid  <= 1'b1;
                feed_kind   <= next_item.kind;
                feed_sample <= next_item.sample;
            end else begin
                feed_valid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls plus one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_stretch != 0 && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = hold_stretch;
        end
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            take_ready <= 1'b0;
        end else begin
            take_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Check each result against the oldest expected height
    always @(posedge i_clk) begin : check_heights
        t_smoothed want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_heights.size() == 0) begin
                $display("%0t: unexpected result height %0d row %0d col %0d last %0b end %0b",
                         $time, out_ch.height, out_ch.row_index, out_ch.column_index,
                         out_ch.last_in_run, out_ch.frame_end);
                mismatch_count++;
            end else begin
                want = expected_heights.pop_front();
                if (out_ch.height !== want.height || out_ch.row_index !== want.row_index ||
                    out_ch.column_index !== want.column_index ||
                    out_ch.last_in_run !== want.last_in_run ||
                    out_ch.frame_end !== want.frame_end) begin
                    $display("%0t: expected height %0d row %0d col %0d last %0b end %0b",
                             $time, want.height, want.row_index, want.column_index,
                             want.last_in_run, want.frame_end);
                    $display("%0t:   actual height %0d row %0d col %0d last %0b end %0b",
                             $time, out_ch.height, out_ch.row_index, out_ch.column_index,
                             out_ch.last_in_run, out_ch.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                stall_ticks <= 0;
            end else if (stall_ticks >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                stall_ticks <= stall_ticks + 1;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_item(logic kind, logic [SAMPLE_W-1:0] sample);
        t_raster_item item;
        item.kind   = kind;
        item.sample = sample;
        raster_feed.push_back(item);
    endtask

    // Queue one frame in raster order followed by its drains, optionally damaged
    task automatic queue_frame(int rows, int cols, t_frame_flaw flaw);
        int k, cut;
        if (flaw == FLAW_JUNK)
            repeat ($urandom_range(3, 6)) push_item(1'($urandom_range(0, 1)), any_sample());
        for (k = 0; k < rows * cols; k++) begin
            push_item(KIND_SAMPLE, any_sample());
            if (flaw == FLAW_STRAY_DRAINS && k + 1 < rows * cols && $urandom_range(0, 3) == 0)
                push_item(KIND_DRAIN, any_sample());
        end
        if (flaw == FLAW_OVERRUN)
            repeat ($urandom_range(1, 4)) push_item(KIND_SAMPLE, any_sample());
        cut = (flaw == FLAW_SHORT_DRAIN) ? $urandom_range(1, cols) : 0;
        for (k = 0; k < cols - cut; k++) push_item(KIND_DRAIN, any_sample());
    endtask

    // Hold until every item is taken and every height has come, then let the block settle
    task automatic wait_idle();
        while (raster_feed.size() != 0 || in_ch.valid || expected_heights.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (index)
            CFG_NUM_ROWS:     rows_reg  = value;
            CFG_NUM_COLUMNS:  cols_reg  = value[NCOLCFG_W-1:0];
            CFG_HEIGHT_SCALE: scale_reg = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Pick new frame sizes and scale; never widen the columns partway through a frame
    task automatic reconfigure();
        int rows, cols, scale;
        logic at_start;
        at_start = !frame_done && cur_row == 0 && cur_col == 0;
        case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = $urandom_range(5, 9);
            default: rows = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 9))
            0:       cols = 0;
            1:       cols = $urandom_range(12, 40);
            default: cols = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 7))
            0:       scale = 0;
            1:       scale = 16'hFFFF;
            2:       scale = 256;
            default: scale = $urandom_range(0, 16'hFFFF);
        endcase
        if (!at_start && ((cols == 0) ? 1 : cols) > cols_in_use()) cols = cols_in_use();
        if ($urandom_range(0, 2) != 0) write_register(CFG_NUM_ROWS, CFG_DATA_W'(rows));
        if ($urandom_range(0, 2) != 0) write_register(CFG_NUM_COLUMNS, CFG_DATA_W'(cols));
        if ($urandom_range(0, 2) != 0) write_register(CFG_HEIGHT_SCALE, CFG_DATA_W'(scale));
    endtask

    // Stimulus
    initial begin
        int k, round, random_count;
        t_frame_flaw flaw;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero sizes act as one: a single-sample frame at full scale
        write_register(CFG_NUM_ROWS, 16'd0);
        write_register(CFG_NUM_COLUMNS, 16'd0);
        write_register(CFG_HEIGHT_SCALE, 16'hFFFF);
        push_item(KIND_SAMPLE, 8'hFF);
        push_item(KIND_SAMPLE, 8'h5A);
        push_item(KIND_DRAIN, 8'h00);
        push_item(KIND_DRAIN, 8'hA5);
        wait_idle();

        // single column at zero scale, led by a drain with nothing pending
        write_register(CFG_NUM_ROWS, 16'd2);
        write_register(CFG_NUM_COLUMNS, 16'd1);
        write_register(CFG_HEIGHT_SCALE, 16'd0);
        push_item(KIND_DRAIN, 8'hFF);
        push_item(KIND_SAMPLE, 8'hFF);
        push_item(KIND_SAMPLE, 8'h00);
        push_item(KIND_DRAIN, 8'h00);
        wait_idle();

        // oversized columns and a tall frame, then shrink both under the input position
        write_register(CFG_NUM_ROWS, 16'hFFFF);
        write_register(CFG_NUM_COLUMNS, 16'd2047);
        write_register(CFG_HEIGHT_SCALE, 16'd256);
        repeat (4) push_item(KIND_SAMPLE, any_sample());
        wait_idle();
        write_register(CFG_NUM_COLUMNS, 16'd2);
        write_register(CFG_NUM_ROWS, 16'd2);
        repeat (3) push_item(KIND_SAMPLE, any_sample());
        push_item(KIND_DRAIN, any_sample());
        wait_idle();
        // shrink under the drain position: the next drain restarts the frame
        write_register(CFG_NUM_COLUMNS, 16'd1);
        push_item(KIND_DRAIN, any_sample());
        wait_idle();

        // 3x3 frame of alternating extremes: corner, edge and center windows
        write_register(CFG_NUM_ROWS, 16'd3);
        write_register(CFG_NUM_COLUMNS, 16'd3);
        write_register(CFG_HEIGHT_SCALE, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        for (k = 0; k < 9; k++) push_item(KIND_SAMPLE, (k % 2) ? 8'h00 : 8'hFF);
        repeat (3) push_item(KIND_DRAIN, any_sample());
        wait_idle();

        // random frames, mostly well formed
        round = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            if (random_count >= 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (random_count >= RANDOM_ITEMS / 3) begin
                src_idle_pct  = 64;
                sink_idle_pct = 12;
            end
            wait_idle();
            reconfigure();
            repeat ($urandom_range(1, 3)) begin
                flaw = ($urandom_range(0, 3) == 0) ? t_frame_flaw'($urandom_range(1, 4))
                                                   : FLAW_NONE;
                queue_frame(rows_in_use(), cols_in_use(), flaw);
                random_count += (rows_in_use() + 1) * cols_in_use();
            end
            // back up the block behind a long receiver hold-off
            if (round == 0) begin
                while (raster_feed.size() < 24) begin
                    queue_frame(rows_in_use(), cols_in_use(), FLAW_NONE);
                    random_count += (rows_in_use() + 1) * cols_in_use();
                end
                @(posedge i_clk);
                hold_stretch = HOLD_TICKS;
            end
            round++;
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
